// ===== src/lenient_base32_decoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// lenient base32 decoder assertion macros
// shared concurrent assertion forms, clocked on clk with reset arst_n
// ----------------------------------------------------------------------------
`ifndef LENIENT_BASE32_DECODER_CORE_DEFINES_SVH
`define LENIENT_BASE32_DECODER_CORE_DEFINES_SVH

// checked only while out of reset
`define LB32_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define LB32_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/lb32_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lb32_pkg
// transaction types, character constants and digit decode for the decoder
// ----------------------------------------------------------------------------
package lb32_pkg;

	typedef struct packed {
		logic [7:0] symbol;
		logic       end_of_text;
	} lb32_in_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       bad_symbol;
		logic       done_res;
	} lb32_out_t;

	typedef struct packed {
		logic       skip;
		logic       ok;
		logic [4:0] val;
	} lb32_dec_t;

	localparam logic [7:0] SymSpace = 8'h20;
	localparam logic [7:0] SymTab   = 8'h09;
	localparam logic [7:0] SymCr    = 8'h0D;
	localparam logic [7:0] SymLf    = 8'h0A;
	localparam logic [7:0] SymDash  = 8'h2D;
	localparam logic [7:0] SymPad   = 8'h3D;
	localparam logic [7:0] SymZero  = 8'h30;
	localparam logic [7:0] SymOne   = 8'h31;
	localparam logic [7:0] SymEight = 8'h38;
	localparam logic [7:0] SymUpO   = 8'h4F;
	localparam logic [7:0] SymUpL   = 8'h4C;
	localparam logic [7:0] SymUpB   = 8'h42;
	localparam logic [4:0] DigitMask = 5'h1F;
	localparam logic [7:0] DigitBias = 8'd24;

	function automatic lb32_dec_t lb32_decode(input logic [7:0] sym);
		lb32_dec_t  r;
		logic [7:0] c;
		logic [7:0] t;
		r = '0;
		c = sym;
		r.skip = (sym inside {SymSpace, SymTab, SymCr, SymLf, SymDash, SymPad});
		if (sym == SymZero) begin
			c = SymUpO;
		end else if (sym == SymOne) begin
			c = SymUpL;
		end else if (sym == SymEight) begin
			c = SymUpB;
		end
		if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
			r.ok  = 1'b1;
			r.val = (c[4:0] & DigitMask) - 5'd1;
		end else if (c inside {[8'h32:8'h37]}) begin
			t     = c - DigitBias;
			r.ok  = 1'b1;
			r.val = t[4:0];
		end
		return r;
	endfunction

endpackage

// ===== src/lenient_base32_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lenient_base32_decoder_core
// streaming base32 text to byte decoder, one character per transaction
// ----------------------------------------------------------------------------
// in_data carries one ASCII character and an end-of-text mark; out_data
// carries a decoded byte, the bad-character flag and the end-of-text mark.
// both channels are valid/ready; a transaction moves when both are high.
// a character is registered at input, then decoded against the held bits
// into the result register. one character per cycle is sustained while the
// receiver takes results; each character depends on the bit buffer as the
// character before it left it, so that buffer update bounds the rate.
// characters that complete no byte and do not end the text give no result.
// when the receiver stalls, the result register holds, the input register
// fills and in_ready drops until out_ready returns.
// arst_n clears the valid flags, the bit buffer, the bit count and the
// error flag; in_ready is high from release on.
// end of text clears buffer, bit count and error flag with its result.
// ----------------------------------------------------------------------------
`include "lenient_base32_decoder_core_defines.svh"

module lenient_base32_decoder_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lb32_pkg::lb32_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lb32_pkg::lb32_out_t out_data
);
	import lb32_pkg::*;

	logic       valid_s1;
	lb32_in_t   item_s1;
	logic       out_valid_q;
	lb32_out_t  out_q;
	logic [11:0] buf_q;
	logic [2:0]  held_q;
	logic        err_q;

	logic        out_free;
	logic        advance;
	lb32_dec_t   dec;
	logic        take_digit;
	logic [11:0] buf_new;
	logic [3:0]  held_sum;
	logic        have_byte;
	logic [7:0]  byte_val;
	logic        err_new;
	logic        has_result;

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_comb begin
		dec        = lb32_decode(item_s1.symbol);
		take_digit = !err_q && !dec.skip && dec.ok;
		err_new    = err_q || (!dec.skip && !dec.ok);
		buf_new    = {buf_q[6:0], dec.val};
		held_sum   = {1'b0, held_q} + 4'd5;
		have_byte  = take_digit && held_sum[3];
		byte_val   = 8'(buf_new >> held_sum[2:0]);
		has_result = have_byte || item_s1.end_of_text;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			held_q <= '0;
			err_q  <= 1'b0;
		end else if (advance) begin
			if (item_s1.end_of_text) begin
				buf_q  <= '0;
				held_q <= '0;
				err_q  <= 1'b0;
			end else begin
				err_q <= err_new;
				if (take_digit) begin
					buf_q  <= buf_new;
					held_q <= held_sum[2:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_q.data_byte  <= have_byte ? byte_val : 8'd0;
			out_q.byte_valid <= have_byte;
			out_q.bad_symbol <= err_new;
			out_q.done_res   <= item_s1.end_of_text;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a result is either a byte or the close of a text
	`LB32_ASSERT(a_result_cause, out_valid |-> (out_data.byte_valid || out_data.done_res),
		"result with neither byte nor end")
	// no byte after a bad character
	`LB32_ASSERT(a_byte_clean, (out_valid && out_data.byte_valid) |-> !out_data.bad_symbol,
		"byte emitted in a bad text")
	// empty results carry a zero byte
	`LB32_ASSERT(a_zero_byte,
		(out_valid && !out_data.byte_valid) |-> (out_data.data_byte == 8'd0),
		"nonzero byte without byte_valid")
	// end of text leaves clean state
	`LB32_ASSERT(a_end_clears,
		(advance && item_s1.end_of_text) |=> (held_q == 3'd0 && !err_q),
		"state not cleared at end of text")
	// reset empties both registers
	`LB32_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> (!out_valid && !valid_s1),
		"valid flag set during reset")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the lenient base32 decoder core
// ----------------------------------------------------------------------------
// characters go in one transaction at a time over in_data; a scoreboard runs
// its own bit-packing model on every accepted character and queues the bytes
// and end-of-text results it expects. every result taken from out_data is
// compared field by field against the oldest queued one. a short directed
// set covers skip characters, typo digits, both letter cases, invalid codes
// and texts that end on a skipped or a bad character; random texts follow,
// mostly well formed, some broken and some pure noise. both sides idle in
// random bursts, and the sender drains the block now and then.
// ----------------------------------------------------------------------------
module tb_top;
	import lb32_pkg::*;

	localparam int ItemTarget = 1850;
	localparam int QuietTail  = 200;
	localparam int StallLimit = 2000;

	class lb32_scoreboard;
		logic [11:0] bit_buf;
		logic [3:0]  nbits;
		logic        err;
		lb32_out_t   pending_results[$];
		int          mismatches;

		function new();
			bit_buf    = '0;
			nbits      = '0;
			err        = 1'b0;
			mismatches = 0;
		endfunction

		function bit is_filler(input logic [7:0] sym);
			return sym == SymSpace || sym == SymTab || sym == SymCr || sym == SymLf ||
				sym == SymDash || sym == SymPad;
		endfunction

		function bit digit_of(input logic [7:0] sym, output logic [4:0] val);
			logic [7:0] c;
			c   = sym;
			val = '0;
			if (sym == SymZero) begin
				c = SymUpO;
			end else if (sym == SymOne) begin
				c = SymUpL;
			end else if (sym == SymEight) begin
				c = SymUpB;
			end
			if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
				val = c[4:0] - 5'd1;
				return 1'b1;
			end
			if (c >= "2" && c <= "7") begin
				val = 5'(c - "2" + 8'd26);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void report(input string msg);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%t: %s", $realtime, msg);
			end
		endfunction

		// bit packing for one accepted character
		function void note_char(input lb32_in_t t);
			lb32_out_t   r;
			logic [11:0] shifted;
			logic [4:0]  d;
			bit          got;
			r   = '0;
			got = 1'b0;
			if (!err && !is_filler(t.symbol)) begin
				if (digit_of(t.symbol, d)) begin
					bit_buf = {bit_buf[6:0], d};
					nbits   = nbits + 4'd5;
					if (nbits >= 4'd8) begin
						shifted     = bit_buf >> (nbits - 4'd8);
						r.data_byte = shifted[7:0];
						nbits       = nbits - 4'd8;
						got         = 1'b1;
					end
				end else begin
					err = 1'b1;
				end
			end
			if (got || t.end_of_text) begin
				r.byte_valid = got;
				r.bad_symbol = err;
				r.done_res   = t.end_of_text;
				pending_results.push_back(r);
			end
			if (t.end_of_text) begin
				bit_buf = '0;
				nbits   = '0;
				err     = 1'b0;
			end
		endfunction

		function void check_result(input lb32_out_t a);
			lb32_out_t e;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result byte=%02h valid=%b bad=%b done=%b",
					a.data_byte, a.byte_valid, a.bad_symbol, a.done_res));
				return;
			end
			e = pending_results.pop_front();
			if (a.data_byte !== e.data_byte || a.byte_valid !== e.byte_valid ||
					a.bad_symbol !== e.bad_symbol || a.done_res !== e.done_res) begin
				report($sformatf({"result mismatch: expected byte=%02h valid=%b bad=%b done=%b,",
					" got byte=%02h valid=%b bad=%b done=%b"},
					e.data_byte, e.byte_valid, e.bad_symbol, e.done_res,
					a.data_byte, a.byte_valid, a.bad_symbol, a.done_res));
			end
		endfunction

		function int pending_count();
			return pending_results.size();
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	lb32_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	lb32_out_t out_data;

	lb32_scoreboard sb = new();
	int             items_sent = 0;
	int             quiet_cycles = 0;
	bit             tail_quiet = 1'b0;
	bit             calm = 1'b0;

	lenient_base32_decoder_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic send_char(input logic [7:0] sym, input logic eot);
		lb32_in_t t;
		t.symbol      = sym;
		t.end_of_text = eot;
		if (!tail_quiet && !calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= t;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic send_text(input string s, input logic eot);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i], eot && i == s.len() - 1);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_count() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_text_char();
		logic [7:0] typos[3];
		logic [7:0] fillers[6];
		typos   = '{SymZero, SymOne, SymEight};
		fillers = '{SymSpace, SymTab, SymCr, SymLf, SymDash, SymPad};
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 8'("A" + $urandom_range(0, 25));
			5, 6:          return 8'("a" + $urandom_range(0, 25));
			7:             return 8'("2" + $urandom_range(0, 5));
			8:             return typos[$urandom_range(0, 2)];
			default:       return fillers[$urandom_range(0, 5)];
		endcase
	endfunction

	function automatic logic [7:0] pick_bad_char();
		logic [7:0] c;
		logic [4:0] v;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (sb.is_filler(c) || sb.digit_of(c, v));
		return c;
	endfunction

	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!tail_quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				sb.check_result(out_data);
			end
			if (in_valid && in_ready) begin
				sb.note_char(in_data);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= StallLimit) begin
					$display("*** FAILED ***");
					$finish;
				end
			end
		end
	end

	initial begin
		int len;
		int kind;
		int bad_at;
		logic [7:0] sym;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// mixed case with fillers, ends on a pad character
		send_text("MZ", 1'b0);
		send_char(SymSpace, 1'b0);
		send_text("xw", 1'b0);
		send_char(SymDash, 1'b0);
		send_text("6Y", 1'b0);
		send_char(SymTab, 1'b0);
		send_text("TB", 1'b0);
		send_char(SymCr, 1'b0);
		send_char(SymLf, 1'b0);
		send_text("Oi", 1'b0);
		send_char(SymPad, 1'b1);
		// typo digits, byte and end together
		send_text("01827", 1'b1);
		// invalid codes, character after error, end on bad character
		send_text("A", 1'b0);
		send_char(8'h80, 1'b0);
		send_text("B", 1'b0);
		send_char(8'hFF, 1'b1);
		send_char(8'h00, 1'b1);
		wait_drained();

		while (items_sent < ItemTarget) begin
			tail_quiet = (items_sent >= ItemTarget - QuietTail);
			calm       = ($urandom_range(0, 3) == 0);
			kind       = $urandom_range(0, 9);
			len        = (kind == 9) ? $urandom_range(1, 10) : $urandom_range(1, 40);
			bad_at     = (kind == 8) ? $urandom_range(0, len - 1) : -1;
			for (int i = 0; i < len; i++) begin
				if (kind == 9) begin
					sym = 8'($urandom_range(0, 255));
				end else if (i == bad_at) begin
					sym = pick_bad_char();
				end else begin
					sym = pick_text_char();
				end
				send_char(sym, i == len - 1);
			end
			if ($urandom_range(0, 24) == 0) begin
				wait_drained();
			end
		end

		wait_drained();
		if (sb.pending_count() != 0) begin
			sb.report($sformatf("%0d results never arrived", sb.pending_count()));
		end
		if (sb.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
